// File: rtl/core/at_ipd_pkg.sv
// Shared types, constants and a helper function for the +IPD frame parser.
package at_ipd_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int unsigned PREFIX_LEN = 5;
    localparam logic [2:0] PREFIX_LAST = 3'(PREFIX_LEN - 1);

    localparam logic [15:0] NUM_SAT = 16'hFFFF;
    localparam logic [7:0]  ID_SAT  = 8'hFF;

    localparam logic [7:0]  MAX_LINK_ID_RESET   = 8'd4;
    localparam logic [15:0] PAYLOAD_LIMIT_RESET = 16'd256;

    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    localparam logic REG_MAX_LINK_ID   = 1'b0;
    localparam logic REG_PAYLOAD_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_NUMBER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef struct packed {
        logic has_digit;
        logic stopped;
        logic negative;
        logic started;
    } nflags_t;

    typedef struct packed {
        logic [15:0] num;
        nflags_t     flags;
    } num_upd_t;

    typedef struct packed {
        logic [7:0]  max_link_id;
        logic [15:0] payload_limit;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  link_id;
        logic        has_id;
        logic [15:0] frame_length;
        logic [7:0]  payload_byte;
        logic        last;
    } res_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = CH_PLUS;
            3'd1:    ch = 8'h49;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h44;
            3'd4:    ch = CH_COMMA;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/core/at_ipd_cfg.sv
// APB register file holding the link id bound and the payload limit.
module at_ipd_cfg
    import at_ipd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [7:0]  max_link_id_reg;
    logic [15:0] payload_limit_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // The byte offset within a word is ignored; bit 2 selects the register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_link_id_reg   <= MAX_LINK_ID_RESET;
            payload_limit_reg <= PAYLOAD_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_MAX_LINK_ID:   max_link_id_reg   <= pwdata[7:0];
                REG_PAYLOAD_LIMIT: payload_limit_reg <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MAX_LINK_ID:   prdata = {24'd0, max_link_id_reg};
            REG_PAYLOAD_LIMIT: prdata = {16'd0, payload_limit_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.max_link_id   = max_link_id_reg;
    assign cfg.payload_limit = payload_limit_reg;

endmodule

// File: rtl/core/at_ipd_core.sv
// Parser state and the combinational next-state and result logic for one byte.
module at_ipd_core
    import at_ipd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output res_t       res
);

    phase_t      phase_reg,  phase_next;
    logic [2:0]  pfx_reg,    pfx_next;
    logic [15:0] first_reg,  first_next;
    logic [15:0] second_reg, second_next;
    nflags_t     flags_reg,  flags_next;
    logic        comma_reg,  comma_next;
    logic [15:0] rem_reg,    rem_next;

    logic [2:0]  pfx_idx;
    logic [15:0] len;
    logic [15:0] count;
    logic [15:0] left;
    num_upd_t    upd;

    // One character of atoi-style number text.
    function automatic num_upd_t feed_digit(input logic [7:0] c, input logic [15:0] num,
                                            input nflags_t f);
        num_upd_t   r;
        logic [19:0] prod;
        logic        blank;
        r.num   = num;
        r.flags = f;
        prod    = {4'd0, num} * 20'd10 + {16'd0, c[3:0]};
        blank   = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        if (!f.stopped)
        begin
            priority if (c >= CH_ZERO && c <= CH_NINE)
            begin
                r.num             = (prod > {4'd0, NUM_SAT}) ? NUM_SAT : prod[15:0];
                r.flags.started   = 1'b1;
                r.flags.has_digit = 1'b1;
            end
            else if (f.started)
                r.flags.stopped = 1'b1;
            else if (blank)
                r.flags = f;
            else if (c == CH_PLUS)
                r.flags.started = 1'b1;
            else if (c == CH_MINUS)
            begin
                r.flags.started  = 1'b1;
                r.flags.negative = 1'b1;
            end
            else
                r.flags.stopped = 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            pfx_reg    <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            flags_reg  <= '0;
            comma_reg  <= 1'b0;
            rem_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            pfx_reg    <= pfx_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            flags_reg  <= flags_next;
            comma_reg  <= comma_next;
            rem_reg    <= rem_next;
        end
    end

    assign pfx_idx = (pfx_reg > PREFIX_LAST) ? 3'd0 : pfx_reg;
    assign upd     = feed_digit(rx_byte, comma_reg ? second_reg : first_reg, flags_reg);
    assign left    = (rem_reg != 16'd0) ? rem_reg - 16'd1 : 16'd0;

    always_comb
    begin
        len = comma_reg ? second_reg : first_reg;
        if (flags_reg.negative || !flags_reg.has_digit)
            len = '0;
    end

    assign count = (len < cfg.payload_limit) ? len : cfg.payload_limit;

    always_comb
    begin
        phase_next  = phase_reg;
        pfx_next    = pfx_reg;
        first_next  = first_reg;
        second_next = second_reg;
        flags_next  = flags_reg;
        comma_next  = comma_reg;
        rem_next    = rem_reg;
        res         = '0;

        unique case (phase_reg)
            PH_PAYLOAD:
            begin
                res.valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = rx_byte;
                res.last         = (left == 16'd0);
                rem_next         = left;
                if (left == 16'd0)
                begin
                    phase_next  = PH_HUNT;
                    pfx_next    = '0;
                    first_next  = '0;
                    second_next = '0;
                    flags_next  = '0;
                    comma_next  = 1'b0;
                end
            end
            PH_NUMBER:
            begin
                priority if (rx_byte == CH_COLON)
                begin
                    res.valid   = 1'b1;
                    phase_next  = PH_HUNT;
                    pfx_next    = '0;
                    first_next  = '0;
                    second_next = '0;
                    flags_next  = '0;
                    comma_next  = 1'b0;
                    rem_next    = '0;
                    if (comma_reg && (first_reg > {8'd0, cfg.max_link_id}))
                    begin
                        res.kind    = KIND_ERROR;
                        res.link_id = (first_reg > {8'd0, ID_SAT}) ? ID_SAT
                                                                   : first_reg[7:0];
                        res.has_id  = 1'b1;
                        res.last    = 1'b1;
                    end
                    else
                    begin
                        res.kind         = KIND_HEADER;
                        res.link_id      = comma_reg ? first_reg[7:0] : 8'd0;
                        res.has_id       = comma_reg;
                        res.frame_length = len;
                        res.last         = (count == 16'd0);
                        if (count != 16'd0)
                        begin
                            phase_next = PH_PAYLOAD;
                            rem_next   = count;
                        end
                    end
                end
                else if (rx_byte == CH_COMMA && !comma_reg)
                begin
                    // A negative nonzero id can never be valid, so pin it high.
                    if (flags_reg.negative && first_reg != 16'd0)
                        first_next = NUM_SAT;
                    comma_next  = 1'b1;
                    flags_next  = '0;
                    second_next = '0;
                end
                else
                begin
                    flags_next = upd.flags;
                    if (comma_reg)
                        second_next = upd.num;
                    else
                        first_next = upd.num;
                end
            end
            default:
            begin
                if (rx_byte == prefix_char(pfx_idx))
                begin
                    if (pfx_idx == PREFIX_LAST)
                    begin
                        phase_next  = PH_NUMBER;
                        pfx_next    = '0;
                        first_next  = '0;
                        second_next = '0;
                        flags_next  = '0;
                        comma_next  = 1'b0;
                        rem_next    = '0;
                    end
                    else
                        pfx_next = pfx_idx + 3'd1;
                end
                else
                    pfx_next = (rx_byte == CH_PLUS) ? 3'd1 : 3'd0;
            end
        endcase
    end

endmodule

// File: rtl/core/at_ipd_frame_parser.sv
// Top level of the +IPD frame parser: input register, parser core, result register.
//
//  Channel   Handshake             Payload
//  --------  --------------------  ------------------------------------------------
//  in        in_valid / in_stall   rx_byte
//  out       out_valid / out_stall kind, link_id, has_id, frame_length,
//                                  payload_byte, last
//  cfg       APB psel/penable      paddr, pwdata, prdata (max_link_id, payload_limit)
//
// A byte passes the input register, which takes it when it is accepted, and then the
// result register, which loads its result once the output is not held by out_stall.
// Unless stalled, one byte is accepted every cycle; the parser advances once per byte.
// While a result waits on out_stall, one more byte is held in the input register.
// Reset returns the parser to prefix hunting and the registers to 4 and 256.
module at_ipd_frame_parser
    import at_ipd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [7:0]        link_id,
    output logic              has_id,
    output logic [15:0]       frame_length,
    output logic [7:0]        payload_byte,
    output logic              last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t       cfg;
    res_t       res;
    res_t       out_reg;
    logic       in_vld_reg, in_vld_next;
    logic       out_vld_reg, out_vld_next;
    logic [7:0] byte_reg;
    logic       out_free;
    logic       fire;
    logic       accept;

    at_ipd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    at_ipd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign out_free = !out_vld_reg || !out_stall;
    assign fire     = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
            in_vld_next = 1'b1;
        else if (fire)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (fire && res.valid)
            out_vld_next = 1'b1;
        else if (out_vld_reg && !out_stall)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            byte_reg <= rx_byte;
        if (fire && res.valid)
            out_reg <= res;
    end

    assign out_valid    = out_vld_reg;
    assign kind         = out_reg.kind;
    assign link_id      = out_reg.link_id;
    assign has_id       = out_reg.has_id;
    assign frame_length = out_reg.frame_length;
    assign payload_byte = out_reg.payload_byte;
    assign last         = out_reg.last;

    // The input side only backs up behind a result that is being held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // A held result must not be overwritten by the next byte.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !fire)
        else $error("parser advanced while result was held");

    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_ERROR) |-> (last && has_id && frame_length == 16'd0))
        else $error("malformed link id error result");

    a_payload_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_PAYLOAD) |-> (!has_id && link_id == 8'd0
                                                 && frame_length == 16'd0))
        else $error("payload result carries header fields");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_HEADER || kind == KIND_PAYLOAD || kind == KIND_ERROR))
        else $error("undefined result kind");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the +IPD frame parser: random framed byte streams against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import at_ipd_pkg::*;

    localparam logic [APB_AW-1:0] ADDR_MAX_LINK_ID   = APB_AW'(4 * REG_MAX_LINK_ID);
    localparam logic [APB_AW-1:0] ADDR_PAYLOAD_LIMIT = APB_AW'(4 * REG_PAYLOAD_LIMIT);

    localparam logic [7:0] IPD_PREFIX [PREFIX_LEN] = '{CH_PLUS, 8'h49, 8'h50, 8'h44, CH_COMMA};
    localparam logic [7:0] BLANKS [6] = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};
    localparam logic [7:0] JUNK [3] = '{CH_SPACE, 8'h78, 8'h2E};

    typedef enum int {SIGN_NONE, SIGN_PLUS, SIGN_MINUS} sign_t;

    class ipd_result_tracker;
        logic [7:0]  max_id;
        logic [15:0] pay_limit;
        phase_t      ph;
        int unsigned matched;
        logic [15:0] num_id;
        logic [15:0] num_len;
        nflags_t     nf;
        bit          split;
        logic [15:0] remaining;
        res_t        awaited[$];
        int unsigned n_mismatch;
        int unsigned n_header;
        int unsigned n_payload;
        int unsigned n_error;

        function new();
            max_id = MAX_LINK_ID_RESET;
            pay_limit = PAYLOAD_LIMIT_RESET;
            n_mismatch = 0;
            n_header = 0;
            n_payload = 0;
            n_error = 0;
            rewind();
        endfunction

        function void rewind();
            ph = PH_HUNT;
            matched = 0;
            num_id = '0;
            num_len = '0;
            nf = '0;
            split = 1'b0;
            remaining = '0;
        endfunction

        // Decimal text is read the way atoi reads it, saturating at the 16-bit maximum.
        function logic [15:0] accumulate(logic [7:0] c, logic [15:0] num);
            logic [31:0] wide;
            if (nf.stopped)
                return num;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                wide = 32'(num) * 10 + 32'(c - CH_ZERO);
                nf.started = 1'b1;
                nf.has_digit = 1'b1;
                return (wide > 32'(NUM_SAT)) ? NUM_SAT : wide[15:0];
            end
            if (!nf.started) begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    return num;
                if (c == CH_PLUS)
                    nf.started = 1'b1;
                else if (c == CH_MINUS)
                begin
                    nf.started = 1'b1;
                    nf.negative = 1'b1;
                end
                else
                    nf.stopped = 1'b1;
            end
            else
                nf.stopped = 1'b1;
            return num;
        endfunction

        function void note_rx_byte(logic [7:0] c);
            res_t        r;
            logic [15:0] len;
            logic [15:0] count;
            r = '0;
            r.valid = 1'b1;
            case (ph)
                PH_PAYLOAD:
                begin
                    if (remaining != 0)
                        remaining--;
                    r.kind = KIND_PAYLOAD;
                    r.payload_byte = c;
                    r.last = (remaining == 0);
                    awaited.push_back(r);
                    if (remaining == 0)
                        rewind();
                end
                PH_NUMBER:
                begin
                    if (c == CH_COLON) begin
                        len = split ? num_len : num_id;
                        if (nf.negative || !nf.has_digit)
                            len = '0;
                        if (split && num_id > max_id) begin
                            r.kind = KIND_ERROR;
                            r.link_id = (num_id > 16'(ID_SAT)) ? ID_SAT : num_id[7:0];
                            r.has_id = 1'b1;
                            r.last = 1'b1;
                            awaited.push_back(r);
                            rewind();
                        end
                        else
                        begin
                            count = (len < pay_limit) ? len : pay_limit;
                            r.kind = KIND_HEADER;
                            r.link_id = split ? num_id[7:0] : 8'd0;
                            r.has_id = split;
                            r.frame_length = len;
                            r.last = (count == 0);
                            awaited.push_back(r);
                            if (count == 0)
                                rewind();
                            else
                            begin
                                ph = PH_PAYLOAD;
                                remaining = count;
                            end
                        end
                    end
                    else if (c == CH_COMMA && !split)
                    begin
                        // A negative id with a nonzero magnitude can never be accepted.
                        if (nf.negative && num_id != 0)
                            num_id = NUM_SAT;
                        split = 1'b1;
                        nf = '0;
                        num_len = '0;
                    end
                    else if (split)
                        num_len = accumulate(c, num_len);
                    else
                        num_id = accumulate(c, num_id);
                end
                default:
                begin
                    if (c == IPD_PREFIX[matched]) begin
                        matched++;
                        if (matched == PREFIX_LEN) begin
                            rewind();
                            ph = PH_NUMBER;
                        end
                    end
                    else
                        matched = (c == CH_PLUS) ? 1 : 0;
                end
            endcase
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (awaited.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: kind %0d id %0d has_id %0b len %0d byte %02h last %0b",
                             got.kind, got.link_id, got.has_id, got.frame_length,
                             got.payload_byte, got.last);
                return;
            end
            want = awaited.pop_front();
            case (want.kind)
                KIND_HEADER:  n_header++;
                KIND_PAYLOAD: n_payload++;
                default:      n_error++;
            endcase
            if (got.kind !== want.kind || got.link_id !== want.link_id
                || got.has_id !== want.has_id || got.frame_length !== want.frame_length
                || got.payload_byte !== want.payload_byte || got.last !== want.last) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("mismatch: expected kind %0d id %0d has_id %0b len %0d byte %02h last %0b",
                             want.kind, want.link_id, want.has_id, want.frame_length,
                             want.payload_byte, want.last);
                    $display("          actual   kind %0d id %0d has_id %0b len %0d byte %02h last %0b",
                             got.kind, got.link_id, got.has_id, got.frame_length,
                             got.payload_byte, got.last);
                end
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        kind;
    logic [7:0]        link_id;
    logic              has_id;
    logic [15:0]       frame_length;
    logic [7:0]        payload_byte;
    logic              last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ipd_result_tracker tracker;
    logic [7:0]        rx_plan[$];
    res_t              seen;
    int                send_gap_pct;
    int                out_stall_pct;
    int unsigned       n_sent;

    at_ipd_frame_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .link_id      (link_id),
        .has_id       (has_id),
        .frame_length (frame_length),
        .payload_byte (payload_byte),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            seen.valid = 1'b1;
            seen.kind = kind_t'(kind);
            seen.link_id = link_id;
            seen.has_id = has_id;
            seen.frame_length = frame_length;
            seen.payload_byte = payload_byte;
            seen.last = last;
            tracker.check_result(seen);
        end
    end

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_MAX_LINK_ID)
            tracker.max_id = data[7:0];
        else if (addr == ADDR_PAYLOAD_LIMIT)
            tracker.pay_limit = data[15:0];
        @(posedge clk);
    endtask

    task automatic send_rx_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_rx_byte(b);
        n_sent++;
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            rx_plan.push_back(s[i]);
    endtask

    task automatic add_number(input int unsigned value, input sign_t sign, input bit empty);
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 2)) rx_plan.push_back(BLANKS[$urandom_range(5)]);
        if (sign == SIGN_PLUS)
            rx_plan.push_back(CH_PLUS);
        else if (sign == SIGN_MINUS)
            rx_plan.push_back(CH_MINUS);
        if (!empty) begin
            if ($urandom_range(7) == 0)
                rx_plan.push_back(CH_ZERO);
            add_text($sformatf("%0d", value));
        end
        if ($urandom_range(7) == 0)
            rx_plan.push_back(JUNK[$urandom_range(2)]);
    endtask

    // Mostly well-formed frames; some noise, cut-off prefixes, open headers and short payloads.
    // Open headers and huge lengths only where the payload limit keeps the swallowed run short.
    task automatic add_frame(input bit risky_ok);
        int unsigned pick;
        int unsigned id_val;
        int unsigned len_val;
        int unsigned eff_id;
        int unsigned eff_len;
        int unsigned count;
        int unsigned lim_small;
        int unsigned i;
        sign_t       id_sign;
        sign_t       len_sign;
        bit          with_id;
        bit          len_empty;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 4)) rx_plan.push_back(8'($urandom_range(255)));
            return;
        end
        if (pick < 14) begin
            count = $urandom_range(3);
            for (i = 0; i <= count; i++)
                rx_plan.push_back(IPD_PREFIX[i]);
            return;
        end
        for (i = 0; i < PREFIX_LEN; i++)
            rx_plan.push_back(IPD_PREFIX[i]);
        with_id = $urandom_range(1);
        eff_id = 0;
        if (with_id) begin
            pick = $urandom_range(9);
            id_sign = (pick == 6) ? SIGN_PLUS : SIGN_NONE;
            if (pick < 7)
                id_val = $urandom_range(int'(tracker.max_id) + 1);
            else if (pick < 9)
                id_val = $urandom_range(300);
            else
            begin
                id_sign = SIGN_MINUS;
                id_val = $urandom_range(2);
            end
            add_number(id_val, id_sign, 1'b0);
            eff_id = (id_sign == SIGN_MINUS && id_val != 0) ? 65535 : id_val;
            rx_plan.push_back(CH_COMMA);
        end
        lim_small = (tracker.pay_limit < 6) ? int'(tracker.pay_limit) + 2 : 6;
        len_sign = SIGN_NONE;
        len_empty = 1'b0;
        pick = $urandom_range(15);
        if (risky_ok && pick == 0)
            len_val = $urandom_range(9999999, 65536);
        else if (risky_ok && pick == 1)
            len_val = $urandom_range(65535, 40);
        else
            len_val = $urandom_range(lim_small);
        if (pick == 2)
            len_sign = SIGN_MINUS;
        else if (pick == 3)
            len_sign = SIGN_PLUS;
        else if (pick == 4)
            len_empty = 1'b1;
        add_number(len_val, len_sign, len_empty);
        if (risky_ok && $urandom_range(19) == 0)
            return;
        // A second comma only ends the length text.
        if (with_id && $urandom_range(5) == 0) begin
            rx_plan.push_back(CH_COMMA);
            rx_plan.push_back(8'h37);
        end
        rx_plan.push_back(CH_COLON);
        if (with_id && eff_id > tracker.max_id)
            return;
        eff_len = (len_sign == SIGN_MINUS || len_empty) ? 0 : ((len_val > 65535) ? 65535 : len_val);
        count = (eff_len < tracker.pay_limit) ? eff_len : tracker.pay_limit;
        if (count > 0 && $urandom_range(19) == 0)
            count--;
        repeat (count) rx_plan.push_back(8'($urandom_range(255)));
    endtask

    task automatic run_phase(input bit program_regs, input logic [7:0] max_id,
                             input logic [15:0] limit, input int gap_pct, input int stall_pct,
                             input bit directed);
        int unsigned target;
        bit          risky_ok;
        if (program_regs) begin
            apb_write(ADDR_MAX_LINK_ID, ($urandom() & 32'hFFFF_FF00) | 32'(max_id));
            apb_write(ADDR_PAYLOAD_LIMIT, ($urandom() & 32'hFFFF_0000) | 32'(limit));
        end
        send_gap_pct = gap_pct;
        out_stall_pct = stall_pct;
        risky_ok = (tracker.pay_limit <= 4096);
        rx_plan.delete();
        if (directed) begin
            // Bad id with empty length, a restarted prefix with a blank and "-0" id,
            // payload bytes at both extremes, and a negative length.
            add_text("+IPD,9,:");
            add_text("++IPD, -0,2:");
            rx_plan.push_back(8'h00);
            rx_plan.push_back(8'hFF);
            add_text("+IPD,-3:");
        end
        target = rx_plan.size() + 80;
        while (rx_plan.size() < target)
            add_frame(risky_ok);
        foreach (rx_plan[i])
            send_rx_byte(rx_plan[i]);
        // Bring the parser back to hunting so the next register write finds it idle.
        while (tracker.ph != PH_HUNT)
            send_rx_byte((tracker.ph == PH_NUMBER) ? CH_COLON : 8'($urandom_range(255)));
        in_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        tracker = new();
        n_sent = 0;
        send_gap_pct = 0;
        out_stall_pct = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        rx_byte <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_phase(1'b0, '0, '0, 0, 0, 1'b1);
        run_phase(1'b1, 8'd0, 16'd1, 49, 0, 1'b0);
        run_phase(1'b1, 8'd255, 16'd65535, 0, 49, 1'b0);
        run_phase(1'b1, 8'($urandom_range(255)), 16'($urandom_range(40, 2)), 12, 12, 1'b0);
        run_phase(1'b1, 8'($urandom_range(255)), 16'($urandom_range(65535, 1)), 0, 0, 1'b0);

        repeat (8) @(posedge clk);
        $display("Sent %0d bytes over five register settings and four idle/stall mixes.", n_sent);
        $display("Checked %0d headers, %0d payload bytes and %0d bad-id errors; %0d mismatches.",
                 tracker.n_header, tracker.n_payload, tracker.n_error, tracker.n_mismatch);
        if (tracker.n_mismatch == 0 && tracker.awaited.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
